// ----- rtl/deflate_bit_packer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the DEFLATE bit packer
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DEFLATE_BIT_PACKER_ASSERT_SVH
`define DEFLATE_BIT_PACKER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define DBP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define DBP_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

// A condition that must hold in the same cycle as the trigger.
`define DBP_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

`endif

// ----- rtl/dbp_pkg.sv -----
// ----------------------------------------------------------------------------
// DEFLATE bit packer package
// Field widths, the bit count limit and the operation codes.
// ----------------------------------------------------------------------------
package dbp_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int MAX_FIELD_BITS = 32;
  // Longest field that one item may write.
  localparam int FIELD_LIMIT    = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
  localparam int COUNT_BITS     = 6;
  localparam int BYTE_BITS      = 8;

  typedef enum logic [1:0] {
    OP_CODE  = 2'd0,  // Huffman code, most significant bit first
    OP_BITS  = 2'd1,  // extra bits, least significant bit first
    OP_RAW   = 2'd2,  // raw byte, only on a byte boundary
    OP_FLUSH = 2'd3   // emit the partial byte
  } op_t;

endpackage

// ----- rtl/dbp_in_if.sv -----
// ----------------------------------------------------------------------------
// DEFLATE bit packer input channel
// Valid/ready channel that carries one packing request per transfer.
// ----------------------------------------------------------------------------
interface dbp_in_if;

  logic                            valid;
  logic                            ready;
  logic [1:0]                      operation;
  logic [dbp_pkg::VALUE_BITS-1:0]  value;
  logic [dbp_pkg::COUNT_BITS-1:0]  bit_count;

  modport source (output valid, output operation, output value, output bit_count,
                  input ready);
  modport sink   (input valid, input operation, input value, input bit_count,
                  output ready);

endinterface

// ----- rtl/dbp_out_if.sv -----
// ----------------------------------------------------------------------------
// DEFLATE bit packer output channel
// Valid/ready channel that carries one packed byte per transfer.
// ----------------------------------------------------------------------------
interface dbp_out_if;

  logic                           valid;
  logic                           ready;
  logic [dbp_pkg::BYTE_BITS-1:0]  out_byte;
  logic                           last;
  logic                           error;

  modport source (output valid, output out_byte, output last, output error,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input error,
                  output ready);

endinterface

// ----- rtl/deflate_bit_packer.sv -----
// ----------------------------------------------------------------------------
// DEFLATE bit packer
// Operation: an item is taken while the engine is idle, then its field moves into
// the partial byte one digit (up to eight bits) per cycle, stalling while a completed
// byte waits for the output stage. No new item is taken until the last is through; a
// 32-bit field takes 4 or 5 digit steps, set by the single byte-wide merge unit.
// Reset (synchronous, rst high) empties the partial byte and the output stage.
// ----------------------------------------------------------------------------
`include "deflate_bit_packer_assert.svh"

module deflate_bit_packer (
  input  logic         clk,
  input  logic         rst,
  dbp_in_if.sink       items,
  dbp_out_if.source    results
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  localparam int BYTE_BITS = dbp_pkg::BYTE_BITS;
  localparam int POS_BITS  = $clog2(BYTE_BITS);
  localparam int TAKE_BITS = POS_BITS + 1;
  localparam int IDX_BITS  = $clog2(dbp_pkg::VALUE_BITS);
  localparam int CNT_BITS  = dbp_pkg::COUNT_BITS;

  // Engine state. The field sits in shift_reg; remaining counts its bits
  // that have not yet been merged into the partial byte.
  state_t                          state;
  dbp_pkg::op_t                    op;
  logic [dbp_pkg::VALUE_BITS-1:0]  shift_reg;
  logic [CNT_BITS-1:0]             remaining;
  logic [BYTE_BITS-1:0]            partial;
  logic [POS_BITS-1:0]             bit_pos;

  // Output stage. It holds one result until the sink takes it, so the
  // engine keeps working while a finished byte waits.
  logic                            out_valid;
  logic [BYTE_BITS-1:0]            out_byte_q;
  logic                            out_last_q;
  logic                            out_error_q;

  logic                            out_free;
  logic                            out_load;
  logic [TAKE_BITS-1:0]            room;
  logic [TAKE_BITS-1:0]            take;
  logic [CNT_BITS-1:0]             rem_after;
  logic [BYTE_BITS-1:0]            code_digit;
  logic [BYTE_BITS-1:0]            digit;
  logic [BYTE_BITS-1:0]            take_mask;
  logic [BYTE_BITS-1:0]            merged;
  logic                            fills;
  logic [CNT_BITS-1:0]             sat_count;

  // The output stage can take a new result when it is empty or when its
  // current result is being transferred in this cycle.
  assign out_free = !out_valid || results.ready;

  // The engine puts a result into the output stage in this cycle: a byte
  // completed by a field, any raw byte request, or a flush with bits pending.
  assign out_load = (state == S_RUN) && out_free &&
                    ((((op == dbp_pkg::OP_CODE) || (op == dbp_pkg::OP_BITS)) &&
                      (remaining != '0) && fills) ||
                     (op == dbp_pkg::OP_RAW) ||
                     ((op == dbp_pkg::OP_FLUSH) && (bit_pos != '0)));

  // Bit counts above the limit are clamped to it.
  assign sat_count = (items.bit_count > CNT_BITS'(dbp_pkg::FIELD_LIMIT))
                     ? CNT_BITS'(dbp_pkg::FIELD_LIMIT) : items.bit_count;

  // One digit step moves as many bits as fit in the partial byte, or what
  // is left of the field if that is fewer.
  assign room      = TAKE_BITS'(BYTE_BITS) - {1'b0, bit_pos};
  assign take      = ({{(CNT_BITS-TAKE_BITS){1'b0}}, room} > remaining)
                     ? remaining[TAKE_BITS-1:0] : room;
  assign rem_after = remaining - {{(CNT_BITS-TAKE_BITS){1'b0}}, take};
  assign fills     = ({1'b0, bit_pos} + take) == TAKE_BITS'(BYTE_BITS);

  // A Huffman code goes out from its top bit down, so its digit is read from
  // the field just below the remaining count and reversed. Extra bits go out
  // from the bottom, so their digit is the low byte of the shift register.
  always_comb begin
    logic [CNT_BITS-1:0] idx;
    for (int j = 0; j < BYTE_BITS; j++) begin
      idx           = remaining - CNT_BITS'(j) - CNT_BITS'(1);
      code_digit[j] = shift_reg[idx[IDX_BITS-1:0]];
    end
  end

  assign digit     = (op == dbp_pkg::OP_CODE) ? code_digit : shift_reg[BYTE_BITS-1:0];
  assign take_mask = BYTE_BITS'(({(BYTE_BITS+1){1'b0}} | (BYTE_BITS+1)'(1) << take)
                     - (BYTE_BITS+1)'(1));
  assign merged    = partial | ((digit & take_mask) << bit_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      remaining <= '0;
      partial   <= '0;
      bit_pos   <= '0;
      out_valid <= 1'b0;
    end else begin
      // A transfer empties the output stage unless a new result lands below.
      if (results.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (items.valid) begin
            op        <= dbp_pkg::op_t'(items.operation);
            shift_reg <= items.value;
            remaining <= sat_count;
            state     <= S_RUN;
          end
        end

        S_RUN: begin
          unique case (op) inside
            dbp_pkg::OP_CODE, dbp_pkg::OP_BITS: begin
              if (remaining == '0) begin
                // Empty field: there is nothing to merge.
                state <= S_IDLE;
              end else if (fills) begin
                // This digit completes a byte; wait for the output stage.
                if (out_free) begin
                  out_valid   <= 1'b1;
                  out_byte_q  <= merged;
                  // Another byte follows only if a full byte of the field is left.
                  out_last_q  <= rem_after < CNT_BITS'(BYTE_BITS);
                  out_error_q <= 1'b0;
                  partial     <= '0;
                  bit_pos     <= '0;
                  remaining   <= rem_after;
                  if (op == dbp_pkg::OP_BITS) begin
                    shift_reg <= shift_reg >> take;
                  end
                  if (rem_after == '0) begin
                    state <= S_IDLE;
                  end
                end
              end else begin
                // The rest of the field fits inside the partial byte.
                partial   <= merged;
                bit_pos   <= bit_pos + take[POS_BITS-1:0];
                remaining <= '0;
                state     <= S_IDLE;
              end
            end

            dbp_pkg::OP_RAW: begin
              // A raw byte off a byte boundary is dropped and reported.
              if (out_free) begin
                out_valid   <= 1'b1;
                out_byte_q  <= (bit_pos != '0) ? '0 : shift_reg[BYTE_BITS-1:0];
                out_last_q  <= 1'b1;
                out_error_q <= bit_pos != '0;
                state       <= S_IDLE;
              end
            end

            dbp_pkg::OP_FLUSH: begin
              if (bit_pos == '0) begin
                state <= S_IDLE;
              end else if (out_free) begin
                out_valid   <= 1'b1;
                out_byte_q  <= partial;
                out_last_q  <= 1'b1;
                out_error_q <= 1'b0;
                partial     <= '0;
                bit_pos     <= '0;
                state       <= S_IDLE;
              end
            end

            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // One item at a time: a new request is taken only once the previous one
  // has put all of its results into the output stage.
  assign items.ready      = (state == S_IDLE);
  assign results.valid    = out_valid;
  assign results.out_byte = out_byte_q;
  assign results.last     = out_last_q;
  assign results.error    = out_error_q;

  `DBP_ASSERT_SAME(a_error_result, results.valid && results.error,
                   (results.out_byte == '0) && results.last,
                   "error result must be a zero final byte")
  `DBP_ASSERT_SAME(a_more_pending, results.valid && !results.last, state == S_RUN,
                   "non-final byte shown while the engine is idle")
  `DBP_ASSERT_NEXT(a_flush_aligns,
                   (state == S_RUN) && (op == dbp_pkg::OP_FLUSH) && out_free,
                   bit_pos == '0, "flush left a partial byte")
  `DBP_ASSERT_ALWAYS(a_count_limit, remaining <= CNT_BITS'(dbp_pkg::FIELD_LIMIT),
                     "remaining bit count above the field limit")

endmodule
